FILE: sv/point_in_polygon_test_assert.svh
// ----------------------------------------------------------------------------
// Point in polygon test - assertion macros
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// next-cycle implication, off while reset is high
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycle
`define PIP_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point in polygon test - package
// Stream field layout, register map, command codes and sequencer states.
// ----------------------------------------------------------------------------
package pip_pkg;

  // input item fields
  localparam int FIELD_W   = 32;
  localparam int VIDX_W    = 6;
  localparam int VIDX_LSB  = 0;
  localparam int X_LSB     = VIDX_LSB + VIDX_W;
  localparam int Y_LSB     = X_LSB + FIELD_W;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 8;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int VC_W       = 7;
  localparam logic [VC_W-1:0] VC_RESET = 7'd3;
  localparam logic [APB_ADDR_W-3:0] REG_VERTEX_COUNT = 1'b0;

  // multiplier limb width (operand b is consumed this many bits per cycle)
  localparam int LIMB_W = 17;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_EDGE,
    ST_MUL,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

FILE: sv/pip_ram.sv
// ----------------------------------------------------------------------------
// Point in polygon test - vertex RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/point_in_polygon_test.sv
// Load item: written at its accept edge, the next item may be accepted in the next cycle.
// Query item: the sequencer visits each edge, n = vertex_count capped at MAX_VERTICES (none when
//   n = 0); a straddling edge gets a multiply over LIMBS limbs and a compare, LIMBS = 2 by default.
// No new item is accepted until the query result enters the result register, which
//   waits while an earlier result is held by a low m_tready.
// Reset (synchronous): sequencer idle, no result pending, vertex_count = 3, RAM not cleared.
// ----------------------------------------------------------------------------
// Point in polygon test - top level
// Ray casting even-odd test over a stored polygon, exact cross-multiplied
// crossing test on one iterated signed multiplier pair.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pip_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pip_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pip_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pip_pkg::S_TDATA_W-1:0]   s_tdata,  // vertex_index[5:0], coord_x[37:6], coord_y[69:38]
  input  logic                            s_tuser,  // cmd
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pip_pkg::M_TDATA_W-1:0]   m_tdata   // inside_res[0]
);

  import pip_pkg::*;

  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int CW    = COORD_BITS + 1;
  localparam int LIMBS = (CW + LIMB_W - 1) / LIMB_W;
  localparam int BW    = LIMBS * LIMB_W;
  localparam int PRW   = CW + LIMB_W + 1;
  localparam int PW    = 2 * COORD_BITS + 2;
  localparam int KW    = $clog2(LIMBS + 1);

  state_t state, state_next;

  // ---------------- configuration ----------------
  logic [VC_W-1:0] vertex_count;
  logic            cfg_wr;
  logic            cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = cfg_hit ? APB_DATA_W'(vertex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (cfg_wr && cfg_hit) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  // ---------------- input fields ----------------
  cmd_t                          cmd;
  logic [VIDX_W-1:0]             vidx;
  logic signed [FIELD_W-1:0]     fx, fy;
  logic signed [COORD_BITS-1:0]  cx, cy;
  logic                          s_acc;
  logic [NW-1:0]                 n_eff;

  assign cmd   = cmd_t'(s_tuser);
  assign vidx  = s_tdata[VIDX_LSB +: VIDX_W];
  assign fx    = signed'(s_tdata[X_LSB +: FIELD_W]);
  assign fy    = signed'(s_tdata[Y_LSB +: FIELD_W]);
  // low COORD_BITS bits of the field, sign taken from bit COORD_BITS-1
  assign cx    = COORD_BITS'(unsigned'(fx));
  assign cy    = COORD_BITS'(unsigned'(fy));
  assign s_tready = (state == ST_IDLE);
  assign s_acc = s_tvalid & s_tready;
  assign n_eff = (int'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vertex_count);

  // ---------------- vertex RAM ----------------
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [2*COORD_BITS-1:0]    rd_data;
  logic signed [COORD_BITS-1:0] xi, yi;

  assign wr_en   = s_acc && (cmd == CMD_LOAD) && (int'(vidx) < MAX_VERTICES);
  assign wr_addr = AW'(vidx);
  assign xi      = signed'(rd_data[COORD_BITS-1:0]);
  assign yi      = signed'(rd_data[2*COORD_BITS-1:COORD_BITS]);

  pip_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_pip_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({cy, cx}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------- edge walk datapath ----------------
  logic signed [COORD_BITS-1:0] px, py, xj, yj;
  logic [AW-1:0]                idx, last_idx;
  logic                         in_flag;
  logic                         is_last;
  logic                         straddle;
  logic signed [CW-1:0]         dxp, d, dxe, dyp;

  // operand a held, operand b shifted out one limb per cycle (top limb first)
  logic signed [CW-1:0]  la, ra;
  logic [BW-1:0]         lb_sh, rb_sh;
  logic signed [LIMB_W:0] limb_l, limb_r;
  logic signed [PRW-1:0] prod_l_c, prod_r_c, prod_l, prod_r;
  logic signed [PW-1:0]  acc_l, acc_r;
  logic                  dneg;
  logic [KW-1:0]         kcnt;
  logic                  hit;
  logic                  out_bit;

  assign is_last  = (idx == last_idx);
  assign straddle = (yi > py) != (yj > py);
  assign dxp = CW'(px) - CW'(xi);
  assign d   = CW'(yj) - CW'(yi);
  assign dxe = CW'(xj) - CW'(xi);
  assign dyp = CW'(py) - CW'(yi);

  // the top limb carries the sign, lower limbs are unsigned
  always_comb begin
    if (kcnt == '0) begin
      limb_l = signed'({lb_sh[BW-1], lb_sh[BW-1 -: LIMB_W]});
      limb_r = signed'({rb_sh[BW-1], rb_sh[BW-1 -: LIMB_W]});
    end else begin
      limb_l = signed'({1'b0, lb_sh[BW-1 -: LIMB_W]});
      limb_r = signed'({1'b0, rb_sh[BW-1 -: LIMB_W]});
    end
  end

  assign prod_l_c = PRW'(la) * PRW'(limb_l);
  assign prod_r_c = PRW'(ra) * PRW'(limb_r);

  // an edge with negative y extent flips the sense of the compare
  assign hit = dneg ? (acc_r < acc_l) : (acc_l < acc_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = idx + AW'(1);
    case (state)
      ST_IDLE: begin
        rd_addr = AW'(n_eff - NW'(1));
        if (s_acc && cmd == CMD_QUERY) begin
          if (n_eff == '0) begin
            state_next = ST_FIN;
          end else begin
            rd_en      = 1'b1;
            state_next = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = ST_EDGE;
      end
      ST_EDGE: begin
        // fetch the next vertex now; RAM output holds through the multiply
        rd_en = !is_last;
        if (straddle) begin
          state_next = ST_MUL;
        end else if (is_last) begin
          state_next = ST_FIN;
        end
      end
      ST_MUL: begin
        if (kcnt == KW'(LIMBS)) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = is_last ? ST_FIN : ST_EDGE;
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px       <= cx;
        py       <= cy;
        in_flag  <= 1'b0;
        last_idx <= AW'(n_eff - NW'(1));
      end
      ST_PRIME: begin
        // closing edge starts at the last vertex
        xj  <= xi;
        yj  <= yi;
        idx <= '0;
      end
      ST_EDGE: begin
        xj    <= xi;
        yj    <= yi;
        la    <= dxp;
        lb_sh <= BW'(d);
        ra    <= dxe;
        rb_sh <= BW'(dyp);
        dneg  <= d[CW-1];
        kcnt  <= '0;
        acc_l <= '0;
        acc_r <= '0;
        if (!straddle && !is_last) begin
          idx <= idx + AW'(1);
        end
      end
      ST_MUL: begin
        kcnt   <= kcnt + KW'(1);
        prod_l <= prod_l_c;
        prod_r <= prod_r_c;
        lb_sh  <= lb_sh << LIMB_W;
        rb_sh  <= rb_sh << LIMB_W;
        if (kcnt != '0) begin
          acc_l <= (acc_l <<< LIMB_W) + PW'(prod_l);
          acc_r <= (acc_r <<< LIMB_W) + PW'(prod_r);
        end
      end
      ST_CMP: begin
        if (hit) begin
          in_flag <= !in_flag;
        end
        if (!is_last) begin
          idx <= idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      out_bit <= in_flag;
    end
  end

  assign m_tdata = M_TDATA_W'(out_bit);

endmodule

FILE: sv/pip_checker.sv
// ----------------------------------------------------------------------------
// Point in polygon test - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_assert.svh"

module pip_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pip_pkg::M_TDATA_W-1:0]  m_tdata
);

  import pip_pkg::*;

  // a stalled result keeps its value
  `PIP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // a query occupies the sequencer
  `PIP_ASSERT_NEXT(a_query_busy, clk, rst, s_tvalid && s_tready && s_tuser == CMD_QUERY, !s_tready, "ready after query accept")

  // a load finishes in its accept cycle
  `PIP_ASSERT_NEXT(a_load_ready, clk, rst, s_tvalid && s_tready && s_tuser == CMD_LOAD, s_tready, "not ready after load")

  // reset leaves the block idle with nothing pending
  `PIP_ASSERT_NEXT_NORST(a_reset_state, clk, rst, s_tready && !m_tvalid, "bad state after reset")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
